// File: rtl/core/bdlp_pkg.sv
// shared types and constants of the button debounce / long-press block
// no dependencies; used by bdlp_tracker and button_debounce_long_press
package bdlp_pkg;

	// register reset values
	localparam logic [15:0] DEBOUNCE_RST   = 16'd30;
	localparam logic [15:0] LONG_PRESS_RST = 16'd2000;
	localparam logic        ACTIVE_LOW_RST = 1'b1;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LOW = 2'd2;
	localparam int unsigned CFG_DATA_W = 16;

	// event codes
	localparam logic [1:0] EV_NONE  = 2'd0;
	localparam logic [1:0] EV_SHORT = 2'd1;
	localparam logic [1:0] EV_LONG  = 2'd2;

	// stream widths
	localparam int unsigned TIME_W   = 32;
	localparam int unsigned S_DATA_W = 40;
	localparam int unsigned M_DATA_W = 8;

	// configuration as seen by the tracker
	typedef struct packed {
		logic [15:0] hold_ms;
		logic [15:0] long_ms;
		logic        active_low;
	} cfg_t;

endpackage

// File: rtl/core/bdlp_tracker.sv
// button state tracker: debounce, press timing and event decision for one sample
// depends on bdlp_pkg
module bdlp_tracker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  bdlp_pkg::cfg_t                   cfg,
	input  logic                             step,
	input  logic                             raw_level,
	input  logic [bdlp_pkg::TIME_W-1:0]      now_ms,
	output logic [1:0]                       press_event
);

	logic                        stable_q;
	logic                        last_sample_q;
	logic [bdlp_pkg::TIME_W-1:0] last_change_q;
	logic [bdlp_pkg::TIME_W-1:0] press_start_q;
	logic                        fired_q;

	logic                        pressed;
	logic                        changed;
	logic [bdlp_pkg::TIME_W-1:0] held;
	logic [bdlp_pkg::TIME_W-1:0] elapsed;
	logic                        accept;
	logic                        stable_n;
	logic                        fired_n;
	logic [bdlp_pkg::TIME_W-1:0] press_start_n;

	// polarity and sample change
	assign pressed = cfg.active_low ? ~raw_level : raw_level;
	assign changed = pressed != last_sample_q;
	assign held    = changed ? '0 : now_ms - last_change_q;
	assign accept  = (held > {16'd0, cfg.hold_ms}) && (pressed != stable_q);

	// next state and event
	always_comb begin
		stable_n      = stable_q;
		fired_n       = fired_q;
		press_start_n = press_start_q;
		press_event   = bdlp_pkg::EV_NONE;
		elapsed       = now_ms - press_start_q;
		if (accept) begin
			stable_n = pressed;
			if (pressed) begin
				press_start_n = now_ms;
				fired_n       = 1'b0;
				elapsed       = '0;
			end else if (!fired_q) begin
				press_event = bdlp_pkg::EV_SHORT;
			end
		end
		// released stable state can never reach the long-press test
		if (stable_n && !fired_n && (elapsed >= {16'd0, cfg.long_ms})) begin
			fired_n     = 1'b1;
			press_event = bdlp_pkg::EV_LONG;
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_q      <= 1'b0;
			last_sample_q <= 1'b0;
			last_change_q <= '0;
			press_start_q <= '0;
			fired_q       <= 1'b0;
		end else if (step) begin
			stable_q      <= stable_n;
			last_sample_q <= pressed;
			if (changed) begin
				last_change_q <= now_ms;
			end
			press_start_q <= press_start_n;
			fired_q       <= fired_n;
		end
	end

endmodule

// File: rtl/core/button_debounce_long_press.sv
// Button debouncer with short- and long-press events. Each request on the s_ side
// carries one pin sample and a wrapping millisecond timestamp and yields exactly one
// event on the m_ side (0 none, 1 short press released, 2 long press reached). A
// request is taken each cycle unless m_tready holds it back: the input register
// captures it, the tracker settles it in a single pass and the event lands in the
// output register. Configuration is written through cfg_* while no request is in
// flight; the user must keep to this, as the block itself leaves it unchecked.
// depends on bdlp_pkg and bdlp_tracker
module button_debounce_long_press (
	input  logic                               clk,
	input  logic                               arst_n,
	// sample requests
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [bdlp_pkg::S_DATA_W-1:0]      s_tdata,   // [0] raw_level, [32:1] now_ms
	// event results
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [bdlp_pkg::M_DATA_W-1:0]      m_tdata,   // [1:0] press_event
	// register writes
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [bdlp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bdlp_pkg::CFG_DATA_W-1:0]    cfg_data
);

	bdlp_pkg::cfg_t cfg_q;

	logic                        valid_s1;
	logic                        level_s1;
	logic [bdlp_pkg::TIME_W-1:0] now_s1;
	logic                        out_valid_q;
	logic [1:0]                  event_q;
	logic                        advance;
	logic [1:0]                  event_d;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hold_ms    <= bdlp_pkg::DEBOUNCE_RST;
			cfg_q.long_ms    <= bdlp_pkg::LONG_PRESS_RST;
			cfg_q.active_low <= bdlp_pkg::ACTIVE_LOW_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				bdlp_pkg::REG_DEBOUNCE:   cfg_q.hold_ms    <= cfg_data;
				bdlp_pkg::REG_LONG_PRESS: cfg_q.long_ms    <= cfg_data;
				bdlp_pkg::REG_ACTIVE_LOW: cfg_q.active_low <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// handshake: stage 1 moves on when the output register is free or drains
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			level_s1 <= s_tdata[0];
			now_s1   <= s_tdata[32:1];
		end
	end

	// event decision and button state
	bdlp_tracker u_tracker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.step        (advance),
		.raw_level   (level_s1),
		.now_ms      (now_s1),
		.press_event (event_d)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || m_tready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			event_q <= event_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, event_q};

endmodule
